@@ design/pwsq_pkg.sv @@
package pwsq_pkg;

    localparam int unsigned CH_W  = 8;
    localparam int unsigned BIN_W = 13;

    localparam int unsigned DEF_CHANNELS = 256;

    localparam logic [BIN_W-1:0] MIN_WIDTH_RST = BIN_W'(10);
    localparam logic [BIN_W-1:0] MIN_SPAN_RST  = BIN_W'(50);

    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_WIDTH = 2'd0,
        REG_MIN_SPAN  = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [BIN_W-1:0] time_bin;
        logic             level;
    } sample_t;

    typedef struct packed {
        logic [CH_W-1:0]  hit_channel;
        logic [BIN_W-1:0] hit_end;
        logic [BIN_W-1:0] pulse_start;
        logic [BIN_W-1:0] pulse_width;
    } hit_t;

endpackage

@@ design/pulse_width_span_qualifier_core.sv @@
// Channel  Handshake                    Payload
// sample   sample_valid / sample_ready  sample (channel, time_bin, level)
// hit      hit_valid / hit_ready        hit (channel, end, start, width)
// cfg      cfg_wr_en                    cfg_index, cfg_data
//
// One word per cycle. A sample reads its channel entry from the state RAM on
// acceptance, is qualified in the next cycle and written back as the qualify
// stage advances; a one-deep forward covers back-to-back same-channel words.
// Reset clears the per-channel valid bits at once; no clearing pass.
// A stalled hit register holds the qualify stage and, through it, sample_ready.
module pulse_width_span_qualifier_core
    import pwsq_pkg::*;
#(
    parameter int unsigned CHANNELS = DEF_CHANNELS
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  sample_t              sample,
    output logic                 hit_valid,
    input  logic                 hit_ready,
    output hit_t                 hit,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BIN_W-1:0]     cfg_data
);

    localparam int unsigned DEPTH = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [BIN_W:0] CH_LIMIT = (BIN_W + 1)'(CHANNELS);

    typedef struct packed {
        logic             in_pulse;
        logic [BIN_W-1:0] open_start;
        logic [BIN_W-1:0] last_start;
    } entry_t;

    logic [BIN_W-1:0] min_width_reg;
    logic [BIN_W-1:0] min_span_reg;

    entry_t             mem [DEPTH];
    logic [DEPTH-1:0]   ent_vld_reg;

    logic               s1_valid_reg;
    logic               s1_ok_reg;
    sample_t            s1_sample_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    entry_t             rd_data_reg;
    logic               rd_vld_reg;
    logic               fwd_hit_reg;
    entry_t             fwd_data_reg;

    logic               hit_valid_reg;
    hit_t               hit_reg;

    logic               sample_accept;
    logic               in_ok;
    logic [IDX_W-1:0]   rd_idx;
    logic               s1_adv;
    logic               wr_en;
    entry_t             cur;
    entry_t             wr_data;
    logic               result;
    logic signed [BIN_W:0] width_s;
    logic signed [BIN_W:0] span_s;
    hit_t               hit_next;

    assign in_ok         = ({1'b0, (BIN_W - CH_W)'(0), sample.channel} < CH_LIMIT);
    assign rd_idx        = sample.channel[IDX_W-1:0];
    assign s1_adv        = s1_valid_reg && (!hit_valid_reg || hit_ready);
    assign sample_ready  = !s1_valid_reg || s1_adv;
    assign sample_accept = sample_valid && sample_ready;
    assign wr_en         = s1_adv && s1_ok_reg;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_width_reg <= MIN_WIDTH_RST;
            min_span_reg  <= MIN_SPAN_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MIN_WIDTH: min_width_reg <= cfg_data;
                REG_MIN_SPAN:  min_span_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // qualify stage
    always_comb
    begin
        if (s1_sample_reg.time_bin == '0)
            cur = '0;
        else if (fwd_hit_reg)
            cur = fwd_data_reg;
        else if (rd_vld_reg)
            cur = rd_data_reg;
        else
            cur = '0;

        width_s  = $signed({1'b0, s1_sample_reg.time_bin}) - $signed({1'b0, cur.open_start});
        span_s   = $signed({1'b0, cur.open_start}) - $signed({1'b0, cur.last_start});
        wr_data  = cur;
        result   = 1'b0;
        hit_next.hit_channel = s1_sample_reg.channel;
        hit_next.hit_end     = s1_sample_reg.time_bin;
        hit_next.pulse_start = cur.open_start;
        hit_next.pulse_width = width_s[BIN_W-1:0];

        if (s1_sample_reg.level)
        begin
            if (!cur.in_pulse)
            begin
                wr_data.in_pulse   = 1'b1;
                wr_data.open_start = s1_sample_reg.time_bin;
            end
        end
        else if (cur.in_pulse)
        begin
            wr_data.in_pulse = 1'b0;
            if ((span_s >= $signed({1'b0, min_span_reg}) || cur.last_start == '0) &&
                width_s >= $signed({1'b0, min_width_reg}))
            begin
                result             = s1_ok_reg;
                wr_data.last_start = cur.open_start;
            end
        end
    end

    // state RAM, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[s1_idx_reg] <= wr_data;
        if (sample_accept)
            rd_data_reg <= mem[rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            s1_sample_reg <= sample;
            s1_idx_reg    <= rd_idx;
            fwd_data_reg  <= wr_data;
        end
        if (s1_adv)
            hit_reg <= hit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_vld_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s1_ok_reg     <= 1'b0;
            rd_vld_reg    <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            hit_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                ent_vld_reg[s1_idx_reg] <= 1'b1;

            if (sample_accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_ok_reg    <= in_ok;
                rd_vld_reg   <= ent_vld_reg[rd_idx];
                fwd_hit_reg  <= wr_en && (s1_idx_reg == rd_idx);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
                fwd_hit_reg  <= 1'b0;
            end

            if (s1_adv)
                hit_valid_reg <= result;
            else if (hit_ready)
                hit_valid_reg <= 1'b0;
        end
    end

    assign hit_valid = hit_valid_reg;
    assign hit       = hit_reg;

    a_fwd_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("forward flag set with empty qualify stage");

    a_hit_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hit_valid) |-> $past(s1_valid_reg && s1_ok_reg))
        else $error("hit without a qualified word");

    a_width_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid |-> (hit.pulse_width == BIN_W'(hit.hit_end - hit.pulse_start)))
        else $error("hit width does not match end minus start");

    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && hit_valid && !hit_ready) |-> !sample_ready)
        else $error("sample taken while qualify stage is stalled");

endmodule

@@ test/pulse_width_span_qualifier_core_tb.sv @@
module pulse_width_span_qualifier_core_tb;
    import pwsq_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
    localparam int unsigned BIN_MAX = (1 << BIN_W) - 1;
    localparam int unsigned SETTLE_CYCLES = 8;

    typedef struct packed {
        sample_t w;
        logic    typed;
        logic    fire;
        hit_t    h;
    } row_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_ready;
    sample_t              sample = '0;
    logic                 hit_valid;
    logic                 hit_ready = 1'b0;
    hit_t                 hit;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BIN_W-1:0]     cfg_data = '0;

    // per-channel pulse tracking
    bit               pulse_open [DEF_CHANNELS];
    logic [BIN_W-1:0] rise_bin   [DEF_CHANNELS];
    logic [BIN_W-1:0] kept_start [DEF_CHANNELS];
    logic [BIN_W-1:0] width_min;
    logic [BIN_W-1:0] span_min;

    // stimulus generator state
    int unsigned gen_bin [DEF_CHANNELS];
    bit          gen_lvl [DEF_CHANNELS];

    hit_t        pending_hits [$];
    row_t        directed_rows [0:23];
    bit          calm = 1'b0;
    int unsigned errors = 0;
    int unsigned words_sent = 0;
    int unsigned hits_seen = 0;

    pulse_width_span_qualifier_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .hit_valid    (hit_valid),
        .hit_ready    (hit_ready),
        .hit          (hit),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            hit_ready <= calm || ($urandom_range(0, 99) >= 12);
        end
    end

    function automatic void qualify_pulse(input sample_t w, output bit fire, output hit_t h);
        int unsigned      c;
        int               wdt;
        int               spn;
        logic [BIN_W-1:0] st;
        logic [BIN_W-1:0] pv;
        c = w.channel;
        fire = 1'b0;
        h = '0;
        if (w.time_bin == 0)
        begin
            pulse_open[c] = 1'b0;
            rise_bin[c] = '0;
            kept_start[c] = '0;
        end
        if (w.level)
        begin
            if (!pulse_open[c])
            begin
                pulse_open[c] = 1'b1;
                rise_bin[c] = w.time_bin;
            end
            return;
        end
        if (!pulse_open[c])
            return;
        pulse_open[c] = 1'b0;
        st = rise_bin[c];
        pv = kept_start[c];
        wdt = int'(w.time_bin) - int'(st);
        spn = int'(st) - int'(pv);
        if ((spn >= int'(span_min) || pv == 0) && wdt >= int'(width_min))
        begin
            kept_start[c] = st;
            fire = 1'b1;
            h.hit_channel = w.channel;
            h.hit_end = w.time_bin;
            h.pulse_start = st;
            h.pulse_width = BIN_W'(wdt);
        end
    endfunction

    function automatic row_t row_pred(int ch, int t, bit lvl);
        row_t r;
        r = '0;
        r.w.channel = CH_W'(ch);
        r.w.time_bin = BIN_W'(t);
        r.w.level = lvl;
        return r;
    endfunction

    function automatic row_t row_quiet(int ch, int t, bit lvl);
        row_t r;
        r = row_pred(ch, t, lvl);
        r.typed = 1'b1;
        return r;
    endfunction

    function automatic row_t row_hit(int ch, int t, bit lvl, int ps, int pw);
        row_t r;
        r = row_quiet(ch, t, lvl);
        r.fire = 1'b1;
        r.h.hit_channel = CH_W'(ch);
        r.h.hit_end = BIN_W'(t);
        r.h.pulse_start = BIN_W'(ps);
        r.h.pulse_width = BIN_W'(pw);
        return r;
    endfunction

    task automatic send_word(input sample_t w, input bit typed, input bit fire, input hit_t h);
        bit   got;
        hit_t ph;
        while (!calm && $urandom_range(0, 99) < 12)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= w;
        do @(posedge clk); while (!sample_ready);
        words_sent++;
        qualify_pulse(w, got, ph);
        if (typed)
        begin
            got = fire;
            ph = h;
        end
        if (got)
            pending_hits.push_back(ph);
    endtask

    task automatic random_words(input int n);
        int          sent;
        int unsigned ch;
        int unsigned nt;
        int unsigned lim;
        int unsigned r;
        bit          lvl;
        sample_t     w;
        sent = 0;
        while (sent < n)
        begin
            r = $urandom_range(0, 99);
            ch = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 7) : $urandom_range(0, 255);
            if (r < 3)
            begin
                // full-scan pulse: widest possible width
                w = '{channel: CH_W'(ch), time_bin: '0, level: 1'b1};
                send_word(w, 1'b0, 1'b0, '0);
                w = '{channel: CH_W'(ch), time_bin: BIN_W'(BIN_MAX), level: 1'b0};
                send_word(w, 1'b0, 1'b0, '0);
                gen_bin[ch] = BIN_MAX;
                gen_lvl[ch] = 1'b0;
                sent += 2;
                continue;
            end
            if (r < 7)
            begin
                nt = 0;
                lvl = $urandom_range(0, 1);
            end
            else if (r < 12)
            begin
                ch = $urandom_range(0, 255);
                nt = $urandom_range(0, BIN_MAX);
                lvl = $urandom_range(0, 1);
            end
            else
            begin
                lim = ((width_min > span_min) ? width_min : span_min) / 2 + 8;
                if (lim > 2000)
                    lim = 2000;
                nt = gen_bin[ch] + $urandom_range(0, lim);
                lvl = ($urandom_range(0, 99) < 70) ? ~gen_lvl[ch] : gen_lvl[ch];
                if (nt > BIN_MAX)
                    nt = 0;
            end
            gen_bin[ch] = nt;
            gen_lvl[ch] = lvl;
            w = '{channel: CH_W'(ch), time_bin: BIN_W'(nt), level: lvl};
            send_word(w, 1'b0, 1'b0, '0);
            sent++;
        end
    endtask

    task automatic drain;
        sample_valid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BIN_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == REG_MIN_WIDTH)
            width_min = val;
        else if (idx == REG_MIN_SPAN)
            span_min = val;
    endtask

    task automatic set_thresholds(input logic [BIN_W-1:0] wmin, input logic [BIN_W-1:0] smin);
        drain();
        write_reg(REG_MIN_WIDTH, wmin);
        write_reg(REG_MIN_SPAN, smin);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        hit_t want;
        if (rst_n && hit_valid && hit_ready)
        begin
            hits_seen++;
            if (pending_hits.size() == 0)
            begin
                errors++;
                $display("%0t mismatch unexpected hit: expected none, actual %h", $time, hit);
            end
            else
            begin
                want = pending_hits.pop_front();
                check_field("hit_channel", 16'(want.hit_channel), 16'(hit.hit_channel));
                check_field("hit_end", 16'(want.hit_end), 16'(hit.hit_end));
                check_field("pulse_start", 16'(want.pulse_start), 16'(hit.pulse_start));
                check_field("pulse_width", 16'(want.pulse_width), 16'(hit.pulse_width));
            end
        end
    end

    initial
    begin
        for (int c = 0; c < DEF_CHANNELS; c++)
        begin
            pulse_open[c] = 1'b0;
            rise_bin[c] = '0;
            kept_start[c] = '0;
            gen_bin[c] = 0;
            gen_lvl[c] = 1'b0;
        end
        width_min = MIN_WIDTH_RST;
        span_min = MIN_SPAN_RST;

        directed_rows = '{
            row_quiet(0, 0, 1),
            row_hit(0, 10, 0, 0, 10),
            row_pred(0, 12, 1),
            row_pred(0, 20, 0),       // too narrow
            row_pred(0, 30, 1),
            row_pred(0, 45, 0),       // prior start was bin zero
            row_pred(0, 60, 1),
            row_pred(0, 75, 0),       // span too short
            row_pred(0, 80, 1),
            row_pred(0, 95, 0),       // span exactly at limit
            row_quiet(255, 0, 0),
            row_quiet(255, 8100, 1),
            row_hit(255, 8191, 0, 8100, 91),
            row_quiet(255, 8191, 1),
            row_quiet(255, 0, 0),     // open pulse dropped by new scan
            row_pred(1, 500, 1),
            row_pred(1, 400, 0),      // negative width
            row_pred(1, 600, 1),
            row_pred(1, 650, 1),
            row_pred(1, 700, 0),
            row_pred(1, 100, 1),
            row_pred(1, 200, 0),      // negative span
            row_pred(2, 7, 1),
            row_pred(2, 7, 0)         // zero width
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].w, directed_rows[i].typed,
                      directed_rows[i].fire, directed_rows[i].h);
        random_words(160);

        set_thresholds('0, '0);
        calm = 1'b1;
        random_words(160);
        calm = 1'b0;

        set_thresholds(BIN_W'(BIN_MAX), BIN_W'(BIN_MAX));
        random_words(160);

        drain();
        write_reg(REG_MIN_WIDTH, BIN_W'(3));
        write_reg(REG_MIN_SPAN, BIN_W'(20));
        write_reg(REG_UNMAPPED, BIN_W'($urandom_range(0, BIN_MAX)));
        cfg_wr_en <= 1'b0;
        random_words(160);

        set_thresholds(BIN_W'($urandom_range(0, BIN_MAX)), BIN_W'($urandom_range(0, BIN_MAX)));
        random_words(160);

        drain();
        $display("Sent %0d sample words over five threshold settings, %0d hits compared.",
                 words_sent, hits_seen);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ pulse_width_span_qualifier_core.f @@
design/pwsq_pkg.sv
design/pulse_width_span_qualifier_core.sv
test/pulse_width_span_qualifier_core_tb.sv
